// ===== sv/spfal_pkg.sv =====
// ----------------------------------------------------------------------------
// spfal_pkg
// shared types and constants for the slot pool allocator
// ----------------------------------------------------------------------------
package spfal_pkg;

	localparam int SLOT_W    = 6;  // width of a slot id on the ports and in the stores
	localparam int CNT_OUT_W = 7;  // width of the reported counts
	localparam int STATUS_W  = 2;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_ACTIVE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_WR,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pop;             // pop free stack, read top entry
		logic set_empty;       // record pool empty result
		logic start_release;   // capture slot, rewind scan
		logic scan;            // issue next active list read
		logic hit_take;        // latch index of matching entry
		logic set_not_active;  // record not active result
		logic grant;           // append popped slot to active list
		logic release_do;      // read last entry, push slot, shrink list
		logic move_wr;         // fill the hole with the last entry
		logic emit;            // load output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_alloc;
		logic pool_empty;
		logic hit;
		logic scan_done;
	} dp_stat_t;

endpackage

// ===== sv/slot_pool_free_active_list.sv =====
// ----------------------------------------------------------------------------
// slot_pool_free_active_list
// fixed pool of slots kept as a free stack plus an unordered active list
// ----------------------------------------------------------------------------
// One request at a time, one result per request. An allocate pops the free
// stack and appends the slot to the active list, then loads its result; when
// the pool is empty it loads the empty result without a pop. A release walks
// the active list from entry zero, one entry per clock through the active list
// memory read port, with the compare in the cycle after the read. A hit loads
// its result after the move, a miss once the walk has passed the last entry,
// and the next request can transfer once the result is loaded. On a hit the
// last active entry is moved into the hole and the slot goes back on the free
// stack. The free stack needs no clearing pass after reset: a low-water mark
// on the stack pointer tells which entries were never pushed, and those read
// as their own index. A finished result sits in an output register, so a new
// request can be taken while the previous result still waits for its transfer;
// a result that finds the register still full waits until it drains.
// ----------------------------------------------------------------------------
module slot_pool_free_active_list import spfal_pkg::*; #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [SLOT_W-1:0]    slot,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    granted_slot,
	output logic [CNT_OUT_W-1:0] free_count,
	output logic [CNT_OUT_W-1:0] active_count
);

	// command and status bundles between sequencer and datapath
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: owns the request handshake and the output valid flag
	spfal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: both stores, the counters and the result payload register
	spfal_dp #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.slot         (slot),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.granted_slot (granted_slot),
		.free_count   (free_count),
		.active_count (active_count)
	);

`ifndef SYNTHESIS
	// every slot is either free or active
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CNT_OUT_W'(free_count + active_count) == CNT_OUT_W'(POOL_SLOTS)))
		else $error("free and active counts do not cover the pool");

	// only a successful allocate hands out a slot
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_DONE)) |-> (granted_slot == '0))
		else $error("granted slot set on a failed request");

	// empty pool is reported only with no free slot left
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY)) |-> (free_count == '0))
		else $error("pool empty reported with free slots");

	// a request keeps the block busy for at least the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in flight");
`endif

endmodule

// ===== sv/spfal_ctrl.sv =====
// ----------------------------------------------------------------------------
// spfal_ctrl
// request sequencer and output valid flag for the slot pool allocator
// ----------------------------------------------------------------------------
module spfal_ctrl import spfal_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (stat.req_alloc) begin
						if (stat.pool_empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_FINISH;
						end else begin
							cmd.pop = 1'b1;
							state_d = S_ALLOC_WR;
						end
					end else begin
						cmd.start_release = 1'b1;
						state_d           = S_SCAN;
					end
				end
			end
			S_ALLOC_WR: begin
				cmd.grant = 1'b1;
				state_d   = S_FINISH;
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.hit_take = 1'b1;
					state_d      = S_MOVE_RD;
				end else if (stat.scan_done) begin
					cmd.set_not_active = 1'b1;
					state_d            = S_FINISH;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_MOVE_RD: begin
				cmd.release_do = 1'b1;
				state_d        = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/spfal_dp.sv =====
// ----------------------------------------------------------------------------
// spfal_dp
// free stack, active list, counters and result register
// ----------------------------------------------------------------------------
module spfal_dp import spfal_pkg::*; #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op,
	input  logic [SLOT_W-1:0]    slot,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    granted_slot,
	output logic [CNT_OUT_W-1:0] free_count,
	output logic [CNT_OUT_W-1:0] active_count
);

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int CNT_W = $clog2(POOL_SLOTS + 1);

	logic [SLOT_W-1:0] free_mem [POOL_SLOTS];
	logic [SLOT_W-1:0] act_mem  [POOL_SLOTS];

	logic [CNT_W-1:0]  free_top_q, low_q, active_total_q;
	logic [CNT_W-1:0]  scan_q;
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  cmp_idx_s1, hit_idx_q, pop_idx_s1;
	logic              pop_fresh_s1;
	logic [SLOT_W-1:0] free_rd_s1, act_rd_s1, slot_q;
	status_t           status_q;
	logic [SLOT_W-1:0] granted_q;

	logic [CNT_W-1:0]  pop_top;
	logic [CNT_W-1:0]  last_idx;
	logic [IDX_W-1:0]  act_rd_addr;
	logic [IDX_W-1:0]  act_wr_addr;
	logic [SLOT_W-1:0] act_wr_data;
	logic              act_we;
	logic [SLOT_W-1:0] got_slot;
	logic              scan_more;

	assign pop_top   = free_top_q - CNT_W'(1);
	assign last_idx  = active_total_q - CNT_W'(1);
	assign scan_more = scan_q < active_total_q;

	// entries below the low-water mark were never pushed and still hold their index
	assign got_slot = pop_fresh_s1 ? SLOT_W'(pop_idx_s1) : free_rd_s1;

	assign act_rd_addr = cmd.release_do ? last_idx[IDX_W-1:0] : scan_q[IDX_W-1:0];
	assign act_we      = cmd.grant | cmd.move_wr;
	assign act_wr_addr = cmd.grant ? active_total_q[IDX_W-1:0] : hit_idx_q;
	assign act_wr_data = cmd.grant ? got_slot : act_rd_s1;

	always_ff @(posedge clk) begin
		free_rd_s1 <= free_mem[pop_top[IDX_W-1:0]];
		if (cmd.release_do && (free_top_q < CNT_W'(POOL_SLOTS))) begin
			free_mem[free_top_q[IDX_W-1:0]] <= slot_q;
		end
	end

	always_ff @(posedge clk) begin
		act_rd_s1 <= act_mem[act_rd_addr];
		if (act_we) begin
			act_mem[act_wr_addr] <= act_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q     <= CNT_W'(POOL_SLOTS);
			low_q          <= CNT_W'(POOL_SLOTS);
			active_total_q <= '0;
			cmp_v_s1       <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.scan && scan_more;
			if (cmd.pop) begin
				free_top_q <= pop_top;
				if (pop_top < low_q) begin
					low_q <= pop_top;
				end
			end
			if (cmd.grant) begin
				active_total_q <= active_total_q + CNT_W'(1);
			end
			if (cmd.release_do) begin
				active_total_q <= last_idx;
				if (free_top_q < CNT_W'(POOL_SLOTS)) begin
					free_top_q <= free_top_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pop_idx_s1   <= pop_top[IDX_W-1:0];
			pop_fresh_s1 <= pop_top < low_q;
		end
		if (cmd.start_release) begin
			slot_q <= slot;
			scan_q <= '0;
		end else if (cmd.scan && scan_more) begin
			scan_q <= scan_q + CNT_W'(1);
		end
		cmp_idx_s1 <= scan_q[IDX_W-1:0];
		if (cmd.hit_take) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (cmd.set_empty) begin
			status_q  <= ST_EMPTY;
			granted_q <= '0;
		end
		if (cmd.set_not_active) begin
			status_q  <= ST_NOT_ACTIVE;
			granted_q <= '0;
		end
		if (cmd.grant) begin
			status_q  <= ST_DONE;
			granted_q <= got_slot;
		end
		if (cmd.release_do) begin
			status_q  <= ST_DONE;
			granted_q <= '0;
		end
		if (cmd.emit) begin
			status       <= status_q;
			granted_slot <= granted_q;
			free_count   <= CNT_OUT_W'(free_top_q);
			active_count <= CNT_OUT_W'(active_total_q);
		end
	end

	assign stat.req_alloc  = (op == OP_ALLOC);
	assign stat.pool_empty = (free_top_q == '0) || (active_total_q >= CNT_W'(POOL_SLOTS));
	assign stat.hit        = cmp_v_s1 && (act_rd_s1 == slot_q);
	assign stat.scan_done  = !cmp_v_s1 && !scan_more;

endmodule
